FILE: design/ordered_list_insert_delete_assert.svh
// Assertion macros for the ordered list block.
`ifndef ORDERED_LIST_INSERT_DELETE_ASSERT_SVH
`define ORDERED_LIST_INSERT_DELETE_ASSERT_SVH

`ifndef SYNTHESIS

// Checked property, disabled while reset is held.
`define OLID_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked property, active during reset as well.
`define OLID_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define OLID_ASSERT(lbl, prop, msg)
`define OLID_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

FILE: design/olid_pkg.sv
// Shared types, codes and constants for the ordered list block.
package olid_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int VAL_W     = 32;
  localparam int REQ_W     = 2;
  localparam int STAT_W    = 2;
  localparam int CNT_OUT_W = 5;
  localparam int IN_DW     = 40;
  localparam int OUT_DW    = 40;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_INS_FRONT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_INS_BACK  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DELETE    = 2'd2;
  localparam logic [REQ_W-1:0] REQ_READ_ALL  = 2'd3;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd2;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd3;

  // Cell load sources
  localparam logic [1:0] SRC_LEFT  = 2'd0;
  localparam logic [1:0] SRC_RIGHT = 2'd1;
  localparam logic [1:0] SRC_NEW   = 2'd2;

  typedef logic signed [VAL_W-1:0] val_t;

  // Per-cell load control
  typedef struct packed {
    logic       en;
    logic [1:0] src;
  } cell_ctl_t;

endpackage

FILE: design/olid_cell.sv
// One list cell: holds an entry, shifts it to a neighbor and compares it to a key.
module olid_cell (
  input  logic              clk,
  input  olid_pkg::cell_ctl_t ctl,
  input  olid_pkg::val_t    left_val,
  input  olid_pkg::val_t    right_val,
  input  olid_pkg::val_t    new_val,
  input  olid_pkg::val_t    key,
  output olid_pkg::val_t    val,
  output logic              eq
);
  import olid_pkg::*;

  val_t val_r;
  val_t val_nxt;

  // Select the load source
  always_comb begin
    unique case (ctl.src)
      SRC_LEFT:  val_nxt = left_val;
      SRC_RIGHT: val_nxt = right_val;
      SRC_NEW:   val_nxt = new_val;
      default:   val_nxt = val_r;
    endcase
  end

  // Entry storage, payload only
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      val_r <= val_nxt;
    end
  end

  assign val = val_r;
  assign eq  = (val_r == key);

endmodule

FILE: design/ordered_list_insert_delete.sv
// Ordered list kept as a circular chain of cells, with a stream request and result port.
// Insert and empty/full results are registered at the request beat and appear in the cycle after it.
// Delete: the match vector is registered at the request beat, then the result is loaded from the delete state.
// Read all: the request moves the block to the read state, then one entry per cycle while out_tready does not stall.
// One insert per cycle while the output is free; no new request is taken until a delete or read-out is done.
// Reset (rst_n low, synchronous) empties the list and clears the output beat.
module ordered_list_insert_delete #(
  parameter int DEPTH = olid_pkg::DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  // [1:0] req_type, [33:2] value, [39:34] zero
  input  logic [olid_pkg::IN_DW-1:0]  in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // [1:0] status, [33:2] item_value, [38:34] count, [39] zero
  output logic [olid_pkg::OUT_DW-1:0] out_tdata,
  output logic                      out_tlast
);
  import olid_pkg::*;

`include "ordered_list_insert_delete_assert.svh"

  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DEL  = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] rd_left_r, rd_left_nxt;
  logic [DEPTH-1:0] match_r;

  logic            out_valid_r;
  logic [STAT_W-1:0] out_stat_r;
  val_t            out_item_r;
  logic            out_last_r;
  logic [CW-1:0]   out_cnt_r;

  logic [REQ_W-1:0] req;
  val_t             in_val;
  logic             acc, out_free, full, empty;
  logic             ins_front, ins_back, del_go, rd_go;
  logic             out_load;
  logic [STAT_W-1:0] ld_stat;
  val_t             ld_item;
  logic             ld_last;
  logic [CW-1:0]    cnt_m1;
  logic [DEPTH-1:0] low_bit, del_mask, occ;
  logic [7:0]       cnt_ext;

  val_t      cell_val [DEPTH];
  logic      cell_eq  [DEPTH];
  cell_ctl_t cell_ctl [DEPTH];
  val_t      new_val;

  // Request fields
  assign req    = in_tdata[1:0];
  assign in_val = in_tdata[33:2];

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && out_free;
  assign acc       = in_tvalid && in_tready;
  assign full      = (count_r == CW'(DEPTH));
  assign empty     = (count_r == '0);
  assign cnt_m1    = count_r - CW'(1);

  assign ins_front = acc && (req == REQ_INS_FRONT) && !full;
  assign ins_back  = acc && (req == REQ_INS_BACK) && !full;
  assign del_go    = (state_r == ST_DEL) && out_free && (match_r != '0);
  assign rd_go     = (state_r == ST_READ) && out_free;

  // First match and every cell behind it shift toward the front
  assign low_bit  = match_r & (~match_r + {{(DEPTH-1){1'b0}}, 1'b1});
  assign del_mask = ~(low_bit - {{(DEPTH-1){1'b0}}, 1'b1});

  // Wrap source during read-out is the front cell
  assign new_val = (state_r == ST_READ) ? cell_val[0] : in_val;

  // Cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    val_t left_v, right_v;

    if (i == 0) begin : g_front
      assign left_v = in_val;
    end else begin : g_mid
      assign left_v = cell_val[i-1];
    end
    if (i == DEPTH - 1) begin : g_back
      assign right_v = cell_val[0];
    end else begin : g_inner
      assign right_v = cell_val[i+1];
    end

    assign occ[i] = (CW'(i) < count_r);

    always_comb begin
      cell_ctl[i].en  = 1'b0;
      cell_ctl[i].src = SRC_LEFT;
      priority if (ins_front) begin
        cell_ctl[i].en  = 1'b1;
        cell_ctl[i].src = SRC_LEFT;
      end else if (ins_back && (CW'(i) == count_r)) begin
        cell_ctl[i].en  = 1'b1;
        cell_ctl[i].src = SRC_NEW;
      end else if (del_go && del_mask[i]) begin
        cell_ctl[i].en  = 1'b1;
        cell_ctl[i].src = SRC_RIGHT;
      end else if (rd_go && (CW'(i) < cnt_m1)) begin
        cell_ctl[i].en  = 1'b1;
        cell_ctl[i].src = SRC_RIGHT;
      end else if (rd_go && (CW'(i) == cnt_m1)) begin
        cell_ctl[i].en  = 1'b1;
        cell_ctl[i].src = SRC_NEW;
      end else begin
        cell_ctl[i].en  = 1'b0;
      end
    end

    olid_cell u_cell (
      .clk       (clk),
      .ctl       (cell_ctl[i]),
      .left_val  (left_v),
      .right_val (right_v),
      .new_val   (new_val),
      .key       (in_val),
      .val       (cell_val[i]),
      .eq        (cell_eq[i])
    );
  end

  // Match vector of the delete key, taken at the request beat
  always_ff @(posedge clk) begin
    if (acc && (req == REQ_DELETE)) begin
      for (int k = 0; k < DEPTH; k++) begin
        match_r[k] <= cell_eq[k] && occ[k];
      end
    end
  end

  // Control sequencer and result selection
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    rd_left_nxt = rd_left_r;
    out_load    = 1'b0;
    ld_stat     = STAT_OK;
    ld_item     = '0;
    ld_last     = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          unique case (req)
            REQ_INS_FRONT, REQ_INS_BACK: begin
              out_load = 1'b1;
              if (full) begin
                ld_stat = STAT_FULL;
              end else begin
                count_nxt = count_r + CW'(1);
              end
            end
            REQ_DELETE: begin
              if (empty) begin
                out_load = 1'b1;
                ld_stat  = STAT_EMPTY;
              end else begin
                state_nxt = ST_DEL;
              end
            end
            default: begin
              if (empty) begin
                out_load = 1'b1;
                ld_stat  = STAT_EMPTY;
              end else begin
                state_nxt   = ST_READ;
                rd_left_nxt = count_r;
              end
            end
          endcase
        end
      end
      ST_DEL: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
          if (match_r == '0) begin
            ld_stat = STAT_NOT_FOUND;
          end else begin
            count_nxt = cnt_m1;
          end
        end
      end
      ST_READ: begin
        if (out_free) begin
          out_load    = 1'b1;
          ld_item     = cell_val[0];
          ld_last     = (rd_left_r == CW'(1));
          rd_left_nxt = rd_left_r - CW'(1);
          if (ld_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      rd_left_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_left_r   <= rd_left_nxt;
      out_valid_r <= out_load || (out_valid_r && !out_tready);
    end
  end

  // Output beat payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_stat_r <= ld_stat;
      out_item_r <= ld_item;
      out_last_r <= ld_last;
      out_cnt_r  <= count_nxt;
    end
  end

  assign cnt_ext    = 8'(out_cnt_r);
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {1'b0, cnt_ext[CNT_OUT_W-1:0], out_item_r, out_stat_r};

  // Checks
  `OLID_ASSERT(a_count_bound, count_r <= CW'(DEPTH), "entry count above depth")
  `OLID_ASSERT(a_del_dec, del_go |=> count_r == $past(cnt_m1), "delete did not drop one entry")
  `OLID_ASSERT(a_read_hold, (state_r == ST_READ) |=> count_r == $past(count_r),
               "count changed during read-out")
  `OLID_ASSERT(a_read_left, (state_r == ST_READ) |-> (rd_left_r <= count_r) && (rd_left_r != '0),
               "read-out counter out of range")
  `OLID_ASSERT_ALWAYS(a_rst_clear, !rst_n |=> !out_tvalid && (count_r == '0),
                      "reset did not clear the list")

endmodule

FILE: tb/sv/ordered_list_insert_delete_test.sv
// Self-checking testbench for the ordered list block: directed and random requests, scoreboarded.
module ordered_list_insert_delete_test;
  timeunit 1ns;
  timeprecision 1ps;

  import olid_pkg::*;

  localparam int DEPTH      = DEPTH_DEF;
  localparam int IDLE_LIMIT = 5000;
  localparam int HOLD_LEN   = 300;
  localparam val_t VAL_MIN  = 32'sh8000_0000;
  localparam val_t VAL_MAX  = 32'sh7fff_ffff;

  // One expected result beat
  typedef struct {
    logic [STAT_W-1:0]    status;
    val_t                 item_value;
    logic                 last;
    logic [CNT_OUT_W-1:0] count;
  } list_result_t;

  // Mirror of the list contents and the queue of results still owed
  class list_scoreboard;
    val_t         held[DEPTH];
    int unsigned  held_n;
    list_result_t owed_q[$];
    int unsigned  errors;

    function void push_result(logic [STAT_W-1:0] st, val_t item, logic last);
      list_result_t r;
      r.status     = st;
      r.item_value = item;
      r.last       = last;
      r.count      = CNT_OUT_W'(held_n);
      owed_q.push_back(r);
    endfunction

    // Apply an accepted request to the mirror and queue its results
    function void note_request(logic [REQ_W-1:0] req, val_t value);
      int unsigned hit;
      hit = held_n;
      case (req)
        REQ_INS_FRONT: begin
          if (held_n >= DEPTH) begin
            push_result(STAT_FULL, '0, 1'b1);
          end else begin
            for (int i = held_n; i > 0; i--) held[i] = held[i-1];
            held[0] = value;
            held_n++;
            push_result(STAT_OK, '0, 1'b1);
          end
        end
        REQ_INS_BACK: begin
          if (held_n >= DEPTH) begin
            push_result(STAT_FULL, '0, 1'b1);
          end else begin
            held[held_n] = value;
            held_n++;
            push_result(STAT_OK, '0, 1'b1);
          end
        end
        REQ_DELETE: begin
          if (held_n == 0) begin
            push_result(STAT_EMPTY, '0, 1'b1);
          end else begin
            for (int i = held_n - 1; i >= 0; i--) if (held[i] == value) hit = i;
            if (hit == held_n) begin
              push_result(STAT_NOT_FOUND, '0, 1'b1);
            end else begin
              for (int i = hit; i + 1 < held_n; i++) held[i] = held[i+1];
              held_n--;
              push_result(STAT_OK, '0, 1'b1);
            end
          end
        end
        default: begin
          if (held_n == 0) push_result(STAT_EMPTY, '0, 1'b1);
          else for (int i = 0; i < held_n; i++) push_result(STAT_OK, held[i], i + 1 == held_n);
        end
      endcase
    endfunction

    // Compare one accepted result beat with the oldest expectation
    function void check_result(logic [OUT_DW-1:0] tdata, logic tlast);
      list_result_t exp_r;
      logic [STAT_W-1:0]    st;
      val_t                 item;
      logic [CNT_OUT_W-1:0] cnt;
      st   = tdata[1:0];
      item = tdata[33:2];
      cnt  = tdata[38:34];
      if (owed_q.size() == 0) begin
        $error("unexpected result beat: status %0d item %0d count %0d", st, item, cnt);
        errors++;
        return;
      end
      exp_r = owed_q.pop_front();
      if (st !== exp_r.status) begin
        $error("status: expected %0d, got %0d", exp_r.status, st);
        errors++;
      end
      if (item !== exp_r.item_value) begin
        $error("item_value: expected %0d, got %0d", exp_r.item_value, item);
        errors++;
      end
      if (tlast !== exp_r.last) begin
        $error("last: expected %0d, got %0d", exp_r.last, tlast);
        errors++;
      end
      if (cnt !== exp_r.count) begin
        $error("count: expected %0d, got %0d", exp_r.count, cnt);
        errors++;
      end
      if (tdata[39] !== 1'b0) begin
        $error("pad bit: expected 0, got %b", tdata[39]);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_DW-1:0]  in_tdata;
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_DW-1:0] out_tdata;
  logic              out_tlast;

  list_scoreboard sb;
  int unsigned    send_idle_pct;
  int unsigned    recv_stall_pct;
  int unsigned    hold_cycles;
  int unsigned    idle_cnt;
  bit             grow;

  ordered_list_insert_delete #(.DEPTH(DEPTH)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Receiver: random stalls, plus a long hold-off when asked
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        hold_cycles--;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
  end

  // Watchdog on cycles without any beat
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  // Offer one request beat, with random idle cycles ahead of it
  task automatic send_req(logic [REQ_W-1:0] req, val_t value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, value, req};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(req, value);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Some small values so that keys repeat, some extremes, the rest anything
  function automatic val_t pick_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 30) return val_t'($urandom_range(6)) - 3;
    if (r < 40) begin
      case ($urandom_range(3))
        0: return VAL_MIN;
        1: return VAL_MAX;
        2: return '0;
        default: return -1;
      endcase
    end
    return val_t'($urandom());
  endfunction

  // Random request; the list drifts between filling up and draining
  task automatic send_random();
    int unsigned  r;
    logic [REQ_W-1:0] req;
    val_t         value;
    if (sb.held_n == 0) grow = 1'b1;
    else if (sb.held_n == DEPTH && $urandom_range(3) == 0) grow = 1'b0;
    else if ($urandom_range(99) < 5) grow = ~grow;
    r = $urandom_range(99);
    if (grow) req = (r < 40) ? REQ_INS_FRONT : (r < 75) ? REQ_INS_BACK :
                    (r < 88) ? REQ_DELETE : REQ_READ_ALL;
    else      req = (r < 10) ? REQ_INS_FRONT : (r < 20) ? REQ_INS_BACK :
                    (r < 85) ? REQ_DELETE : REQ_READ_ALL;
    value = pick_value();
    // most deletes aim at a key that is held
    if (req == REQ_DELETE && sb.held_n != 0 && $urandom_range(99) < 75)
      value = sb.held[$urandom_range(sb.held_n - 1)];
    send_req(req, value);
  endtask

  task automatic run_phase(int unsigned n, int unsigned idle_pct, int unsigned stall_pct,
                           bit with_hold);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int k = 0; k < n; k++) begin
      if (with_hold && k == 20) hold_cycles = HOLD_LEN;
      send_random();
    end
    wait_drained();
  endtask

  initial begin
    sb             = new();
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 0;
    idle_cnt       = 0;
    grow           = 1'b1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty cases, extremes, duplicates, no match, full list
    send_req(REQ_READ_ALL, '0);
    send_req(REQ_DELETE, '0);
    send_req(REQ_INS_FRONT, VAL_MIN);
    send_req(REQ_INS_BACK, VAL_MAX);
    send_req(REQ_INS_FRONT, -1);
    send_req(REQ_INS_BACK, '0);
    send_req(REQ_READ_ALL, VAL_MAX);
    send_req(REQ_DELETE, 12345);
    send_req(REQ_INS_BACK, -1);
    send_req(REQ_DELETE, -1);
    send_req(REQ_READ_ALL, '0);
    for (int k = 0; k < 12; k++)
      send_req(k[0] ? REQ_INS_BACK : REQ_INS_FRONT, val_t'(k * 32'h1111_1111));
    send_req(REQ_INS_FRONT, 7);
    send_req(REQ_INS_BACK, 8);
    send_req(REQ_READ_ALL, '0);
    send_req(REQ_DELETE, VAL_MAX);
    send_req(REQ_DELETE, sb.held[sb.held_n - 1]);
    wait_drained();

    // Random phases: no idling, sender idle, receiver stalling, both
    run_phase(110, 0, 0, 1'b1);
    run_phase(110, 85, 0, 1'b0);
    run_phase(110, 0, 85, 1'b0);
    run_phase(110, 23, 23, 1'b0);

    repeat (24) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
